/* sv/bprs_pkg.sv */
// Shared types, constants and divider constants for the basis point ratio scaler.
`default_nettype none
package bprs_pkg;

    localparam int DENOMINATOR = 10000;

    localparam int AMT_W   = 64;
    localparam int RATIO_W = 14;
    localparam int HALF_W  = AMT_W / 2;
    localparam int PP_W    = HALF_W + RATIO_W;
    localparam int PROD_W  = AMT_W + RATIO_W;

    // Long division by the denominator, one byte of the product per step.
    localparam int DIGIT_W = 8;
    localparam int STEPS   = (PROD_W + DIGIT_W - 1) / DIGIT_W;
    localparam int DIV_W   = STEPS * DIGIT_W;
    localparam int REM_W   = $clog2(DENOMINATOR);
    localparam int X_W     = REM_W + DIGIT_W;
    localparam int SHIFT_K = X_W + REM_W;
    localparam int M_W     = X_W + 2;
    localparam int P_W     = X_W + M_W;
    localparam longint unsigned RECIP_VAL =
        ((longint'(1) << SHIFT_K) + longint'(DENOMINATOR) - 1) / longint'(DENOMINATOR);
    localparam logic [M_W-1:0] RECIP = M_W'(RECIP_VAL);
    localparam logic [X_W-1:0] DEN_X = X_W'(DENOMINATOR);

    // Back pipeline: multiply, add, two stages per division step, output.
    localparam int NSTG = 3 + 2 * STEPS;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [AMT_W-1:0]   amount;
        logic [RATIO_W-1:0] ratio_bp;
        logic               ceil_mode;
        logic               error;
    } t_item;

    typedef struct packed {
        logic ceil_mode;
        logic error;
    } t_side;

endpackage
`default_nettype wire

/* sv/bprs_front.sv */
// Input stage: take a word, flag an out-of-range ratio, hand it to the queue.
`default_nettype none
module bprs_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [bprs_pkg::AMT_W-1:0]    i_amount,
    input  wire logic [bprs_pkg::RATIO_W-1:0]  i_ratio_bp,
    input  wire logic                          i_ceil_mode,
    output logic                               o_push,
    output bprs_pkg::t_item                    o_item,
    input  wire logic                          i_q_ready
);

    logic            r_valid;
    bprs_pkg::t_item r_item;
    bprs_pkg::t_item n_item;
    logic            take;
    logic            bad_ratio;

    assign o_push  = r_valid && i_q_ready;
    assign o_ready = !r_valid || i_q_ready;
    assign take    = i_valid && o_ready;
    assign o_item  = r_item;

    // A bad ratio is replaced by zero so the back end yields a zero result.
    always_comb begin
        bad_ratio        = 32'(i_ratio_bp) > 32'(bprs_pkg::DENOMINATOR);
        n_item.amount    = i_amount;
        n_item.ratio_bp  = bad_ratio ? '0 : i_ratio_bp;
        n_item.ceil_mode = i_ceil_mode;
        n_item.error     = bad_ratio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

/* sv/bprs_queue.sv */
// Short register queue between the front and back parts.
`default_nettype none
module bprs_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bprs_pkg::t_item  i_item,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output bprs_pkg::t_item       o_item
);

    bprs_pkg::t_item                r_mem [bprs_pkg::QDEPTH];
    logic [bprs_pkg::QPTR_W-1:0]    r_wp;
    logic [bprs_pkg::QPTR_W-1:0]    r_rp;
    logic [bprs_pkg::QCNT_W-1:0]    r_cnt;
    logic                           do_pop;

    assign o_ready = r_cnt != bprs_pkg::QCNT_W'(bprs_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == bprs_pkg::QDEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (32'(r_rp) == bprs_pkg::QDEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule
`default_nettype wire

/* sv/bprs_back.sv */
// Back pipeline: form amount * ratio, divide by the denominator a byte per step, round.
`default_nettype none
module bprs_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire bprs_pkg::t_item             i_item,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [bprs_pkg::AMT_W-1:0]       o_scaled,
    output logic                             o_error
);

    logic                          r_vld [bprs_pkg::NSTG];
    bprs_pkg::t_side               r_sb  [bprs_pkg::NSTG];
    logic                          en;

    logic [bprs_pkg::PP_W-1:0]     r_plo;
    logic [bprs_pkg::PP_W-1:0]     r_phi;
    logic [bprs_pkg::DIV_W-1:0]    r_w   [bprs_pkg::STEPS+1];
    logic [bprs_pkg::REM_W-1:0]    r_rem [bprs_pkg::STEPS+1];
    logic [bprs_pkg::X_W-1:0]      r_x   [bprs_pkg::STEPS];
    logic [bprs_pkg::P_W-1:0]      r_p   [bprs_pkg::STEPS];
    logic [bprs_pkg::DIV_W-1:0]    r_wa  [bprs_pkg::STEPS];
    logic [bprs_pkg::AMT_W-1:0]    r_scaled;

    // Advance the whole line unless the output word is held.
    assign en       = !r_vld[bprs_pkg::NSTG-1] || i_ready;
    assign o_pop    = en && i_q_valid;
    assign o_valid  = r_vld[bprs_pkg::NSTG-1];
    assign o_error  = r_sb[bprs_pkg::NSTG-1].error;
    assign o_scaled = r_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < bprs_pkg::NSTG; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_q_valid;
            for (int s = 1; s < bprs_pkg::NSTG; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0].ceil_mode <= i_item.ceil_mode;
            r_sb[0].error     <= i_item.error;
            for (int s = 1; s < bprs_pkg::NSTG; s++) begin
                r_sb[s] <= r_sb[s-1];
            end
            // Two half-width partial products, then their sum.
            r_plo <= bprs_pkg::PP_W'(i_item.amount[bprs_pkg::HALF_W-1:0])
                     * bprs_pkg::PP_W'(i_item.ratio_bp);
            r_phi <= bprs_pkg::PP_W'(i_item.amount[bprs_pkg::AMT_W-1:bprs_pkg::HALF_W])
                     * bprs_pkg::PP_W'(i_item.ratio_bp);
            r_w[0]   <= (bprs_pkg::DIV_W'(r_phi) << bprs_pkg::HALF_W)
                        + bprs_pkg::DIV_W'(r_plo);
            r_rem[0] <= '0;
        end
    end

    for (genvar i = 0; i < bprs_pkg::STEPS; i++) begin : g_step
        logic [bprs_pkg::X_W-1:0]     x;
        logic [bprs_pkg::DIGIT_W-1:0] q;
        logic [bprs_pkg::X_W-1:0]     rem_full;

        assign x        = {r_rem[i], r_w[i][bprs_pkg::DIV_W-1 -: bprs_pkg::DIGIT_W]};
        assign q        = r_p[i][bprs_pkg::SHIFT_K +: bprs_pkg::DIGIT_W];
        assign rem_full = r_x[i] - bprs_pkg::X_W'(q) * bprs_pkg::DEN_X;

        always_ff @(posedge i_clk) begin
            if (en) begin
                // Quotient digit by reciprocal multiply, exact for this width.
                r_x[i]  <= x;
                r_p[i]  <= bprs_pkg::P_W'(x) * bprs_pkg::P_W'(bprs_pkg::RECIP);
                r_wa[i] <= r_w[i];
                // Drop the consumed top byte and shift the digit in at the low end.
                r_w[i+1]   <= {r_wa[i][bprs_pkg::DIV_W-bprs_pkg::DIGIT_W-1:0], q};
                r_rem[i+1] <= rem_full[bprs_pkg::REM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_scaled <= r_w[bprs_pkg::STEPS][bprs_pkg::AMT_W-1:0]
                        + bprs_pkg::AMT_W'(r_sb[bprs_pkg::NSTG-2].ceil_mode
                                           && (r_rem[bprs_pkg::STEPS] != '0));
        end
    end

endmodule
`default_nettype wire

/* sv/basis_point_ratio_scaler.sv */
// Top level of the basis point ratio scaler.
// Scales a 64-bit amount by ratio_bp / 10000, rounded down or, with i_ceil_mode set,
// up; a ratio above 10000 gives scaled = 0 with error set. One word is taken and
// one result given every clock cycle when neither side stalls. From input to output
// a word passes one input register, a slot of the two-entry queue, and a 23-stage
// back pipeline (partial products, sum, two stages for each of the ten byte steps
// of the division by the denominator, and the rounding add). The queue lets the
// input side keep taking words for a short while after the output side stops.
`default_nettype none
module basis_point_ratio_scaler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [bprs_pkg::AMT_W-1:0]    i_amount,
    input  wire logic [bprs_pkg::RATIO_W-1:0]  i_ratio_bp,
    input  wire logic                          i_ceil_mode,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [bprs_pkg::AMT_W-1:0]         o_scaled,
    output logic                               o_error
);

    logic            push;
    logic            q_ready;
    logic            q_valid;
    logic            pop;
    bprs_pkg::t_item front_item;
    bprs_pkg::t_item q_item;

    bprs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_amount    (i_amount),
        .i_ratio_bp  (i_ratio_bp),
        .i_ceil_mode (i_ceil_mode),
        .o_push      (push),
        .o_item      (front_item),
        .i_q_ready   (q_ready)
    );

    bprs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    bprs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_scaled  (o_scaled),
        .o_error   (o_error)
    );

endmodule
`default_nettype wire
